// File: rtl/core/fbtp_pkg.sv
// Shared constants for the Bezier time-to-position block.
package fbtp_pkg;

    localparam int FRAC_BITS_DEF    = 6;
    localparam int SIGNAL_SCALE_DEF = 8192;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int WORD_W     = 32;
    localparam int CNT_W      = 5;
    localparam int SEARCH_W   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_START_TIME     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_MS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_HANDLE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_HANDLE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_LEVEL      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_END_HANDLE_X   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_END_HANDLE_Y   = 3'd7;

endpackage

// File: rtl/core/fixed_bezier_time_to_position.sv
// Cubic Bezier motion curve evaluation: time in milliseconds to fixed-point position.
//
// A request is taken when start is high and busy is low; one result follows on
// o_level_fixed and o_movement_fixed, marked by a single-cycle o_done pulse that
// cannot be held off. All lerp products run through one shared shift-and-add
// multiplier that consumes one bit of u per cycle. An item runs R bisection
// rounds of six lerps for x(u), where R is at most about FRAC_BITS+2, then six
// lerps for y(u), and ends with a one-bit-per-cycle division by SIGNAL_SCALE.
module fixed_bezier_time_to_position #(
    parameter int FRAC_BITS    = fbtp_pkg::FRAC_BITS_DEF,
    parameter int SIGNAL_SCALE = fbtp_pkg::SIGNAL_SCALE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [31:0]                      i_now_ms,
    input  logic                             i_cfg_we,
    input  logic [fbtp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fbtp_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output logic                             o_done,
    output logic [21:0]                      o_level_fixed,
    output logic [15:0]                      o_movement_fixed
);
    import fbtp_pkg::*;

    localparam int U_W   = FRAC_BITS + 1;
    localparam int IT_W  = $clog2(2 * FRAC_BITS + 9);
    localparam int LIMIT = 2 * FRAC_BITS + 8;
    localparam int REM_W = $clog2(SIGNAL_SCALE + 1) + 1;
    localparam logic [U_W-1:0]   U_ONE     = U_W'(1) << FRAC_BITS;
    localparam logic [REM_W-1:0] SCALE_R   = REM_W'(SIGNAL_SCALE);
    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(FRAC_BITS);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(WORD_W - 1);

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MUL, S_CHECK, S_DIV} t_state;
    typedef enum logic [3:0] {
        OP_P11, OP_P12, OP_P13, OP_P21, OP_P22, OP_EX,
        OP_Q11, OP_Q12, OP_Q13, OP_Q21, OP_Q22, OP_Y
    } t_op;

    // Configuration registers
    logic [31:0] r_start_time;
    logic [15:0] r_span_ms;
    logic [13:0] r_start_level;
    logic [16:0] r_start_handle_x;
    logic [15:0] r_start_handle_y;
    logic [13:0] r_end_level;
    logic [16:0] r_end_handle_x;
    logic [15:0] r_end_handle_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_time     <= '0;
            r_span_ms        <= '0;
            r_start_level    <= '0;
            r_start_handle_x <= '0;
            r_start_handle_y <= '0;
            r_end_level      <= '0;
            r_end_handle_x   <= '0;
            r_end_handle_y   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_TIME:     r_start_time     <= i_cfg_wdata[31:0];
                REG_SPAN_MS:        r_span_ms        <= i_cfg_wdata[15:0];
                REG_START_LEVEL:    r_start_level    <= i_cfg_wdata[13:0];
                REG_START_HANDLE_X: r_start_handle_x <= i_cfg_wdata[16:0];
                REG_START_HANDLE_Y: r_start_handle_y <= i_cfg_wdata[15:0];
                REG_END_LEVEL:      r_end_level      <= i_cfg_wdata[13:0];
                REG_END_HANDLE_X:   r_end_handle_x   <= i_cfg_wdata[16:0];
                REG_END_HANDLE_Y:   r_end_handle_y   <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Control points derived at request time
    logic [31:0] c_dur, c_sy, c_scx, c_scy, c_ey, c_ecy, c_ecx, c_x;
    logic [34:0] c_endx, c_endsum;

    always_comb begin
        c_dur  = 32'(r_span_ms) << FRAC_BITS;
        c_sy   = 32'(r_start_level) << FRAC_BITS;
        c_scx  = 32'($signed(r_start_handle_x)) << FRAC_BITS;
        c_scy  = (32'(r_start_level) + 32'($signed(r_start_handle_y))) << FRAC_BITS;
        c_ey   = 32'(r_end_level) << FRAC_BITS;
        c_ecy  = (32'(r_end_level) + 32'($signed(r_end_handle_y))) << FRAC_BITS;
        c_endx = 35'(r_start_time) + 35'(r_span_ms);
        c_endsum = c_endx + 35'($signed(r_end_handle_x));
        // An end control that would land before time zero is pulled to time zero.
        if (c_endsum[34])
            c_ecx = (32'd0 - c_endx[31:0]) << FRAC_BITS;
        else
            c_ecx = 32'($signed(r_end_handle_x)) << FRAC_BITS;
        c_x = (i_now_ms - r_start_time) << FRAC_BITS;
    end

    t_state          r_state;
    t_op             r_op;
    logic [31:0]     r_dur, r_sy, r_scx, r_scy, r_ey, r_ecy, r_ecx, r_x;
    logic [31:0]     r_t [6];
    logic [U_W-1:0]  r_u, r_lo, r_hi;
    logic [IT_W-1:0] r_iter;
    logic            r_bail;
    logic [SEARCH_W-1:0] r_search;
    logic [31:0]     r_md, r_acc;
    logic [U_W-1:0]  r_mul;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]     r_quo;
    logic [REM_W-1:0] r_rem;

    // Operand selection for the lerp about to start
    logic [31:0]    l_a, l_b, l_diff, l_d, l_base;
    logic [U_W-1:0] l_m;
    logic           l_signed;

    always_comb begin
        l_a = '0;
        l_b = '0;
        l_signed = 1'b0;
        case (r_op)
            OP_P12: begin l_a = r_scx;         l_b = r_dur + r_ecx; end
            OP_P13: begin l_a = r_dur + r_ecx; l_b = r_dur;         end
            OP_P21: begin l_a = r_t[0];        l_b = r_t[1];        end
            OP_P22: begin l_a = r_t[1];        l_b = r_t[2];        end
            OP_EX:  begin l_a = r_t[3];        l_b = r_t[4];        end
            OP_Q11: begin l_a = r_sy;  l_b = r_scy; l_signed = 1'b1; end
            OP_Q12: begin l_a = r_scy; l_b = r_ecy; l_signed = 1'b1; end
            OP_Q13: begin l_a = r_ecy; l_b = r_ey;  l_signed = 1'b1; end
            OP_Q21: begin l_a = r_t[0]; l_b = r_t[1]; l_signed = 1'b1; end
            OP_Q22: begin l_a = r_t[1]; l_b = r_t[2]; l_signed = 1'b1; end
            OP_Y:   begin l_a = r_t[3]; l_b = r_t[4]; l_signed = 1'b1; end
            default: ;
        endcase
        l_diff = l_b - l_a;
        if (r_op == OP_P11) begin
            l_d    = r_scx >> FRAC_BITS;
            l_m    = r_u;
            l_base = '0;
        end else if (l_signed) begin
            l_d    = 32'($signed(l_diff) >>> FRAC_BITS);
            l_m    = r_u;
            l_base = l_a;
        end else if (l_b < l_a) begin
            l_d    = (32'd0 - l_diff) >> FRAC_BITS;
            l_m    = U_ONE - r_u;
            l_base = l_b;
        end else begin
            l_d    = l_diff >> FRAC_BITS;
            l_m    = r_u;
            l_base = l_a;
        end
    end

    logic [31:0]    n_acc, n_y, n_ex_gap;
    logic [2:0]     n_slot;
    logic           n_stop, n_above;
    logic [U_W-1:0] n_lo, n_hi;
    logic [REM_W-1:0] n_rem_sh;

    always_comb begin
        n_acc = r_acc + (r_mul[0] ? r_md : 32'd0);
        n_y   = n_acc[31] ? 32'd0 : n_acc;
        case (r_op)
            OP_P11, OP_Q11: n_slot = 3'd0;
            OP_P12, OP_Q12: n_slot = 3'd1;
            OP_P13, OP_Q13: n_slot = 3'd2;
            OP_P21, OP_Q21: n_slot = 3'd3;
            OP_P22, OP_Q22: n_slot = 3'd4;
            default:        n_slot = 3'd5;
        endcase
        n_above  = r_t[5] > r_x;
        n_ex_gap = n_above ? (r_t[5] - r_x) : (r_x - r_t[5]);
        n_stop   = (n_ex_gap < 32'(U_ONE)) || r_bail || (r_iter >= IT_W'(LIMIT));
        n_lo = r_lo;
        n_hi = r_hi;
        if (n_above)
            n_hi = r_u;
        else if (r_t[5] < r_x)
            n_lo = r_u;
        n_rem_sh = {r_rem[REM_W-2:0], r_quo[31]};
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_P11;
            r_search <= SEARCH_W'(2);
            o_done   <= 1'b0;
            r_cnt    <= '0;
            r_u      <= '0;
            r_lo     <= '0;
            r_hi     <= '0;
            r_iter   <= '0;
            r_bail   <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_dur <= c_dur;
                        r_sy  <= c_sy;
                        r_scx <= c_scx;
                        r_scy <= c_scy;
                        r_ey  <= c_ey;
                        r_ecy <= c_ecy;
                        r_ecx <= c_ecx;
                        r_x   <= c_x;
                        r_u   <= (r_search > SEARCH_W'(U_ONE)) ? U_ONE : r_search[U_W-1:0];
                        r_lo  <= '0;
                        r_hi  <= U_ONE;
                        r_iter <= '0;
                        r_bail <= 1'b0;
                        r_op   <= OP_P11;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_md    <= l_d;
                    r_mul   <= l_m;
                    r_acc   <= l_base;
                    r_cnt   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_acc <= n_acc;
                    r_md  <= r_md << 1;
                    r_mul <= r_mul >> 1;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == MUL_LAST) begin
                        r_t[n_slot] <= n_acc;
                        if (r_op == OP_EX) begin
                            r_state <= S_CHECK;
                        end else if (r_op == OP_Y) begin
                            // Clamped height goes to the divider as its dividend.
                            r_quo   <= n_y;
                            r_rem   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_DIV;
                        end else begin
                            r_op    <= t_op'(r_op + 4'd1);
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_CHECK: begin
                    if (n_stop) begin
                        r_search <= SEARCH_W'(r_u) + SEARCH_W'(1);
                        r_op     <= OP_Q11;
                    end else begin
                        r_lo   <= n_lo;
                        r_hi   <= n_hi;
                        r_u    <= ((n_hi - n_lo) >> 1) + n_lo;
                        r_bail <= (n_hi - n_lo) <= U_W'(1);
                        r_iter <= r_iter + IT_W'(1);
                        r_op   <= OP_P11;
                    end
                    r_state <= S_LOAD;
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    if (n_rem_sh >= SCALE_R) begin
                        r_rem <= n_rem_sh - SCALE_R;
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= n_rem_sh;
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == DIV_LAST) begin
                        o_done <= 1'b1;
                        o_level_fixed <= (r_t[5][31] || r_t[5] > 32'd4194303) ?
                                         (r_t[5][31] ? 22'd0 : 22'h3FFFFF) : r_t[5][21:0];
                        o_movement_fixed <= (r_quo[30:15] != 16'd0) ? 16'hFFFF :
                                            {r_quo[14:0], (n_rem_sh >= SCALE_R)};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy)) else $error("result without a request in flight");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result strobe while still busy");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("request not taken");
    a_u_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_u <= U_ONE && r_lo <= r_hi)) else $error("search bounds broken");

endmodule

// File: test/tb.sv
// Self-checking testbench for the Bezier time-to-position block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fbtp_pkg::*;

    localparam int          F        = FRAC_BITS_DEF;
    localparam logic [31:0] U_ONE    = 32'd1 << F;
    localparam int          MAX_ROUNDS = 2 * F + 8;

    typedef struct packed {
        logic [21:0] level;
        logic [15:0] movement;
    } t_position;

    logic        i_clk, i_rst_n, start, busy;
    logic [31:0] i_now_ms;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic        o_done;
    logic [21:0] o_level_fixed;
    logic [15:0] o_movement_fixed;

    fixed_bezier_time_to_position dut (.*);

    // Shadow copy of the curve registers and the search seed.
    logic [31:0] crv_start_time;
    logic [15:0] crv_span;
    logic [13:0] crv_start_lvl, crv_end_lvl;
    logic [16:0] crv_start_hx, crv_end_hx;
    logic [15:0] crv_start_hy, crv_end_hy;
    logic [15:0] next_guess;

    t_position   pending_pos[$];
    int          error_count = 0;
    int          requests_sent = 0;
    int          results_seen = 0;
    int          phases_run = 0;
    bit          gaps_on = 1;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [31:0] asr_f(input logic [31:0] x);
        return $unsigned($signed(x) >>> F);
    endfunction

    function automatic logic [31:0] lerp_s(input logic [31:0] a, b, u);
        logic [31:0] d;
        d = b - a;
        return asr_f(d) * u + a;
    endfunction

    function automatic logic [31:0] lerp_u(input logic [31:0] a, b, u);
        logic [31:0] d;
        if (b < a) begin
            d = a - b;
            return (d >> F) * (U_ONE - u) + b;
        end
        d = b - a;
        return (d >> F) * u + a;
    endfunction

    // Bisection for u over x(u), then y(u); updates the search seed.
    function automatic t_position eval_position(input logic [31:0] now);
        logic [31:0] dur, sy, scx, scy, ey, ecy, ecx, x, u, lo, hi;
        logic [31:0] p11, p12, p13, p21, p22, ex, delta;
        logic [31:0] q11, q12, q13, q21, q22, y, mv;
        longint      ehx, endx;
        bit          bail;
        int          iter;
        t_position   r;
        dur  = {16'b0, crv_span} << F;
        sy   = {18'b0, crv_start_lvl} << F;
        scx  = {{15{crv_start_hx[16]}}, crv_start_hx} << F;
        scy  = ({18'b0, crv_start_lvl} + {{16{crv_start_hy[15]}}, crv_start_hy}) << F;
        ey   = {18'b0, crv_end_lvl} << F;
        ecy  = ({18'b0, crv_end_lvl} + {{16{crv_end_hy[15]}}, crv_end_hy}) << F;
        ehx  = longint'($signed(crv_end_hx));
        endx = longint'({32'b0, crv_start_time}) + longint'({48'b0, crv_span});
        if (endx + ehx < 0)
            ecx = (32'd0 - endx[31:0]) << F;
        else
            ecx = {{15{crv_end_hx[16]}}, crv_end_hx} << F;
        x    = (now - crv_start_time) << F;
        u    = ({16'b0, next_guess} > U_ONE) ? U_ONE : {16'b0, next_guess};
        lo   = 0;
        hi   = U_ONE;
        bail = 0;
        iter = 0;
        while (1) begin
            p11 = (scx >> F) * u;
            p12 = lerp_u(scx, dur + ecx, u);
            p13 = lerp_u(dur + ecx, dur, u);
            p21 = lerp_u(p11, p12, u);
            p22 = lerp_u(p12, p13, u);
            ex  = lerp_u(p21, p22, u);
            delta = (ex > x) ? ex - x : x - ex;
            if (delta < U_ONE || bail || iter >= MAX_ROUNDS)
                break;
            if (ex > x)
                hi = u;
            else if (ex < x)
                lo = u;
            u = (hi - lo) / 2 + lo;
            if (hi - lo <= 1)
                bail = 1;
            iter++;
        end
        q11 = lerp_s(sy, scy, u);
        q12 = lerp_s(scy, ecy, u);
        q13 = lerp_s(ecy, ey, u);
        q21 = lerp_s(q11, q12, u);
        q22 = lerp_s(q12, q13, u);
        y   = lerp_s(q21, q22, u);
        if (y[31])
            y = 0;
        next_guess = u[15:0] + 16'd1;
        mv = y / SIGNAL_SCALE_DEF;
        r.level    = (y > 32'd4194303) ? 22'h3FFFFF : y[21:0];
        r.movement = (mv > 32'd65535) ? 16'hFFFF : mv[15:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got, exp_v);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp_v);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            results_seen++;
            if (pending_pos.size() == 0) begin
                report_mismatch("unexpected result", 32'd1, 32'd0);
            end else begin
                t_position e;
                e = pending_pos.pop_front();
                if (o_level_fixed !== e.level)
                    report_mismatch("level_fixed", 32'(o_level_fixed), 32'(e.level));
                if (o_movement_fixed !== e.movement)
                    report_mismatch("movement_fixed", 32'(o_movement_fixed),
                                    32'(e.movement));
            end
        end
    end

    // Sends one time request; start stays high when the next one follows at once.
    task automatic send_time(input logic [31:0] now);
        int gap;
        gap = gaps_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_now_ms <= now;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        pending_pos.push_back(eval_position(now));
        requests_sent++;
        @(posedge i_clk);
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_pos.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Register writes happen only with the block idle; bits above width are random.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        logic [31:0] v;
        v = val;
        case (idx)
            REG_START_TIME:     crv_start_time = v;
            REG_SPAN_MS:        begin v[31:16] = 16'($urandom); crv_span = v[15:0]; end
            REG_START_LEVEL:    begin v[31:14] = 18'($urandom); crv_start_lvl = v[13:0]; end
            REG_START_HANDLE_X: begin v[31:17] = 15'($urandom); crv_start_hx = v[16:0]; end
            REG_START_HANDLE_Y: begin v[31:16] = 16'($urandom); crv_start_hy = v[15:0]; end
            REG_END_LEVEL:      begin v[31:14] = 18'($urandom); crv_end_lvl = v[13:0]; end
            REG_END_HANDLE_X:   begin v[31:17] = 15'($urandom); crv_end_hx = v[16:0]; end
            REG_END_HANDLE_Y:   begin v[31:16] = 16'($urandom); crv_end_hy = v[15:0]; end
            default: ;
        endcase
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
    endtask

    task automatic set_curve(input logic [31:0] t0, input int span, sl, shx, shy,
                             el, ehx, ehy);
        drain();
        write_reg(REG_START_TIME, t0);
        write_reg(REG_SPAN_MS, span);
        write_reg(REG_START_LEVEL, sl);
        write_reg(REG_START_HANDLE_X, shx);
        write_reg(REG_START_HANDLE_Y, shy);
        write_reg(REG_END_LEVEL, el);
        write_reg(REG_END_HANDLE_X, ehx);
        write_reg(REG_END_HANDLE_Y, ehy);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        phases_run++;
    endtask

    task automatic test_reset_curve;
        send_time(32'd0);
        send_time(32'hFFFF_FFFF);
        send_time(32'd12345);
    endtask

    task automatic test_edges;
        set_curve(32'd1000, 65535, 8192, 65535, 16384, 8192, -65536, -16384);
        send_time(32'd999);
        send_time(32'd1000);
        send_time(32'd1000 + 32768);
        send_time(32'd1000 + 65535);
        send_time(32'hFFFF_FFFF);
        send_time(32'd0);
        // End handle pulled before time zero, negative heights clamp to zero.
        set_curve(32'd5, 40, 0, -65536, -16384, 0, -65536, -16384);
        send_time(32'd5);
        send_time(32'd25);
        send_time(32'd45);
        set_curve(32'hFFFF_FFFF, 0, 8192, 0, 0, 8192, 65535, 16384);
        send_time(32'hFFFF_FFFF);
        send_time(32'd0);
        set_curve(32'd0, 1, 0, 0, 0, 8192, 0, 0);
        send_time(32'd0);
        send_time(32'd1);
        send_time(32'd2);
    endtask

    function automatic int pick_handle_x(input int span);
        case ($urandom_range(0, 5))
            0:       return -65536;
            1:       return 65535;
            2:       return $urandom_range(0, 131071) - 65536;
            default: return $urandom_range(0, span / 2 + 1) *
                            (($urandom_range(0, 3) == 0) ? -1 : 1);
        endcase
    endfunction

    task automatic test_random_curves;
        logic [31:0] t0, now;
        int span, n;
        for (int ph = 0; ph < 20; ph++) begin
            gaps_on = (ph % 4 != 3);
            t0   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100000);
            span = ($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(1, 3000);
            set_curve(t0, span, $urandom_range(0, 8192), pick_handle_x(span),
                      $urandom_range(0, 32768) - 16384, $urandom_range(0, 8192),
                      pick_handle_x(span), $urandom_range(0, 32768) - 16384);
            n = 95;
            for (int k = 0; k < n; k++) begin
                case ($urandom_range(0, 9))
                    0:       now = $urandom;
                    1:       now = t0 - $urandom_range(0, 50);
                    2:       now = t0 + span + $urandom_range(0, 50);
                    default: now = t0 + $urandom_range(0, span);
                endcase
                send_time(now);
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_now_ms    = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        crv_start_time = '0; crv_span = '0; crv_start_lvl = '0; crv_end_lvl = '0;
        crv_start_hx = '0; crv_end_hx = '0; crv_start_hy = '0; crv_end_hy = '0;
        next_guess = 16'd2;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_curve();
        test_edges();
        test_random_curves();
        drain();
        repeat (50) @(posedge i_clk);

        $display("Evaluated %0d time requests over %0d curve settings, %0d results checked.",
                 requests_sent, phases_run, results_seen);
        if (error_count == 0 && pending_pos.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// File: sim.f
rtl/core/fbtp_pkg.sv
rtl/core/fixed_bezier_time_to_position.sv
test/tb.sv
